FILE: design/lcd_command_packet_translator_core_assert.svh
// Assertion macros for the checker file of the LCD packet translator.
`ifndef LCD_COMMAND_PACKET_TRANSLATOR_CORE_ASSERT_SVH
`define LCD_COMMAND_PACKET_TRANSLATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LCPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lcd_cpt_pkg.sv
`default_nettype none
package lcd_cpt_pkg;

    localparam int LCD_BUFFER_DEPTH = 32;

    localparam int IN_BYTE_W  = 7;
    localparam int LCD_BYTE_W = 8;
    localparam int QUAL_W     = 5;

    localparam logic [1:0] OP_STRING  = 2'd0;
    localparam logic [1:0] OP_CONFIG  = 2'd1;
    localparam logic [1:0] OP_GOTO    = 2'd2;
    localparam logic [1:0] OP_GENERIC = 2'd3;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_STRING = 2'd1;
    localparam logic [1:0] PH_GOTO   = 2'd2;

    localparam logic [QUAL_W-1:0] QUAL_CFG_ONE_LINE  = 5'd0;
    localparam logic [QUAL_W-1:0] QUAL_CFG_TWO_LINE  = 5'd1;
    localparam logic [QUAL_W-1:0] QUAL_CFG_LARGE     = 5'd2;
    localparam logic [QUAL_W-1:0] QUAL_CFG_SIZE3     = 5'd3;
    localparam logic [QUAL_W-1:0] QUAL_GEN_VERSION   = 5'd0;
    localparam logic [QUAL_W-1:0] QUAL_GEN_CLEAR     = 5'd1;

    localparam logic [LCD_BYTE_W-1:0] CMD_CLEAR    = 8'h01;
    localparam logic [LCD_BYTE_W-1:0] CMD_FUNCTION = 8'h30;
    localparam logic [LCD_BYTE_W-1:0] CMD_ADDRESS  = 8'h80;

    localparam logic [1:0] DISPLAY_MODE_RESET = 2'd2;

    localparam logic [QUAL_W-1:0] VERSION_LAST = 5'd14;

    typedef enum logic [1:0] {
        EMIT_NONE    = 2'd0,
        EMIT_SINGLE  = 2'd1,
        EMIT_STRING  = 2'd2,
        EMIT_VERSION = 2'd3
    } t_emit;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load_single;
        logic rd_mem;
        logic load_str;
        logic load_ver;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_emit emit;
        logic  slot_free;
        logic  str_last;
        logic  ver_last;
    } t_dp_status;

    function automatic logic [LCD_BYTE_W-1:0] line_offset(input logic [1:0] row);
        logic [LCD_BYTE_W-1:0] v;
        unique case (row)
            2'd0: v = 8'h00;
            2'd1: v = 8'h40;
            2'd2: v = 8'h14;
            2'd3: v = 8'h54;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // "LCD display v.2"
    function automatic logic [IN_BYTE_W-1:0] version_char(input logic [QUAL_W-1:0] idx);
        logic [IN_BYTE_W-1:0] c;
        unique case (idx)
            5'd0:  c = 7'h4C;
            5'd1:  c = 7'h43;
            5'd2:  c = 7'h44;
            5'd3:  c = 7'h20;
            5'd4:  c = 7'h64;
            5'd5:  c = 7'h69;
            5'd6:  c = 7'h73;
            5'd7:  c = 7'h70;
            5'd8:  c = 7'h6C;
            5'd9:  c = 7'h61;
            5'd10: c = 7'h79;
            5'd11: c = 7'h20;
            5'd12: c = 7'h76;
            5'd13: c = 7'h2E;
            5'd14: c = 7'h32;
            default: c = 7'h20;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: design/lcd_cpt_dp.sv
`default_nettype none
module lcd_cpt_dp #(
    parameter int BUFFER_DEPTH = lcd_cpt_pkg::LCD_BUFFER_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [lcd_cpt_pkg::IN_BYTE_W-1:0]  i_in_byte,
    input  wire lcd_cpt_pkg::t_ctrl_cmd             i_cmd,
    input  wire logic                               i_out_ready,
    output lcd_cpt_pkg::t_dp_status                 o_status,
    output logic                                    o_out_valid,
    output logic                                    o_out_is_data,
    output logic [lcd_cpt_pkg::LCD_BYTE_W-1:0]      o_out_byte,
    output logic                                    o_out_last
);
    import lcd_cpt_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [1:0]            r_phase, n_phase;
    logic [QUAL_W-1:0]     r_len, n_len;
    logic [QUAL_W-1:0]     r_idx, n_idx;
    logic [1:0]            r_mode, n_mode;
    logic                  r_font, n_font;
    logic [1:0]            r_row, n_row;
    logic [QUAL_W-1:0]     r_cnt;
    logic [IN_BYTE_W-1:0]  r_rd_data;
    logic [LCD_BYTE_W-1:0] r_single, n_single;
    logic                  r_single_is_data;
    logic                  r_out_valid;
    logic                  r_out_is_data;
    logic [LCD_BYTE_W-1:0] r_out_byte;
    logic                  r_out_last;
    logic [IN_BYTE_W-1:0]  r_mem [BUFFER_DEPTH];

    logic [1:0]        w_op;
    logic [QUAL_W-1:0] w_qual;
    logic [QUAL_W-1:0] w_idx_inc;
    t_emit             w_emit;
    logic              w_mem_we;

    assign w_op      = i_in_byte[6:5];
    assign w_qual    = i_in_byte[QUAL_W-1:0];
    assign w_idx_inc = r_idx + 5'd1;

    // Packet decode: next parse state and what the accepted byte emits.
    always_comb begin
        n_phase  = PH_HEADER;
        n_len    = r_len;
        n_idx    = r_idx;
        n_mode   = r_mode;
        n_font   = r_font;
        n_row    = r_row;
        n_single = r_single;
        w_emit   = EMIT_NONE;
        w_mem_we = 1'b0;
        unique case (r_phase)
            PH_STRING: begin
                w_mem_we = 1'b1;
                if (w_idx_inc >= r_len) begin
                    w_emit = EMIT_STRING;
                    n_idx  = '0;
                end else begin
                    n_idx   = w_idx_inc;
                    n_phase = PH_STRING;
                end
            end
            PH_GOTO: begin
                n_single = CMD_ADDRESS | (line_offset(r_row) + {1'b0, i_in_byte});
                w_emit   = EMIT_SINGLE;
            end
            default: begin
                unique case (w_op)
                    OP_STRING: begin
                        n_len = w_qual;
                        n_idx = '0;
                        if (w_qual != '0) begin
                            n_phase = PH_STRING;
                        end
                    end
                    OP_CONFIG: begin
                        if (w_qual == QUAL_CFG_ONE_LINE || w_qual == QUAL_CFG_TWO_LINE ||
                            w_qual == QUAL_CFG_SIZE3) begin
                            n_mode = w_qual[1:0];
                            if (w_qual[1:0] != 2'd0) begin
                                n_font = 1'b0;
                            end
                            w_emit = EMIT_SINGLE;
                        end else if (w_qual == QUAL_CFG_LARGE) begin
                            if (r_mode != 2'd0) begin
                                n_font = 1'b1;
                            end
                            w_emit = EMIT_SINGLE;
                        end
                        n_single = CMD_FUNCTION | {4'd0, (n_mode != 2'd0), n_font, 2'd0};
                    end
                    OP_GOTO: begin
                        n_row   = w_qual[1:0];
                        n_phase = PH_GOTO;
                    end
                    default: begin
                        if (w_qual == QUAL_GEN_VERSION) begin
                            w_emit = EMIT_VERSION;
                        end else if (w_qual == QUAL_GEN_CLEAR) begin
                            n_single = CMD_CLEAR;
                            w_emit   = EMIT_SINGLE;
                        end
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_len   <= '0;
            r_idx   <= '0;
            r_mode  <= DISPLAY_MODE_RESET;
            r_font  <= 1'b0;
            r_row   <= '0;
        end else if (i_cmd.accept) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_mode  <= n_mode;
            r_font  <= n_font;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_single         <= n_single;
            r_single_is_data <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cnt <= '0;
        end else if (i_cmd.load_str || i_cmd.load_ver) begin
            r_cnt <= r_cnt + 5'd1;
        end
    end

    // Character buffer: one write port at accept, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_mem_we) begin
            r_mem[r_idx[AW-1:0]] <= i_in_byte;
        end
        if (i_cmd.rd_mem) begin
            r_rd_data <= r_mem[r_cnt[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_single || i_cmd.load_str || i_cmd.load_ver) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.load_single) begin
            r_out_is_data <= r_single_is_data;
            r_out_byte    <= r_single;
            r_out_last    <= 1'b1;
        end else if (i_cmd.load_str) begin
            r_out_is_data <= 1'b1;
            r_out_byte    <= {1'b0, r_rd_data};
            r_out_last    <= (r_cnt == r_len - 5'd1);
        end else if (i_cmd.load_ver) begin
            r_out_is_data <= 1'b1;
            r_out_byte    <= {1'b0, version_char(r_cnt)};
            r_out_last    <= (r_cnt == VERSION_LAST);
        end
    end

    assign o_status.emit      = w_emit;
    assign o_status.slot_free = !r_out_valid || i_out_ready;
    assign o_status.str_last  = (r_cnt == r_len - 5'd1);
    assign o_status.ver_last  = (r_cnt == VERSION_LAST);

    assign o_out_valid   = r_out_valid;
    assign o_out_is_data = r_out_is_data;
    assign o_out_byte    = r_out_byte;
    assign o_out_last    = r_out_last;

endmodule
`default_nettype wire

FILE: design/lcd_cpt_ctrl.sv
`default_nettype none
module lcd_cpt_ctrl (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  wire lcd_cpt_pkg::t_dp_status i_status,
    output logic                         o_in_ready,
    output lcd_cpt_pkg::t_ctrl_cmd       o_cmd
);
    import lcd_cpt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SINGLE = 5'b00010,
        S_STR_RD = 5'b00100,
        S_STR_WR = 5'b01000,
        S_VER    = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.accept = w_accept;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_status.emit)
                        EMIT_SINGLE:  n_state = S_SINGLE;
                        EMIT_STRING:  n_state = S_STR_RD;
                        EMIT_VERSION: n_state = S_VER;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_SINGLE: begin
                if (i_status.slot_free) begin
                    o_cmd.load_single = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_STR_RD: begin
                o_cmd.rd_mem = 1'b1;
                n_state = S_STR_WR;
            end
            S_STR_WR: begin
                if (i_status.slot_free) begin
                    o_cmd.load_str = 1'b1;
                    n_state = i_status.str_last ? S_IDLE : S_STR_RD;
                end
            end
            S_VER: begin
                if (i_status.slot_free) begin
                    o_cmd.load_ver = 1'b1;
                    if (i_status.ver_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

FILE: design/lcd_command_packet_translator_core.sv
// Character-LCD packet translator. Bytes of 7 bits arrive on the slave stream, one
// per transfer; each packet is a header (opcode in bits 6:5, qualifier in bits 4:0)
// and an optional payload. The master stream carries the resulting display writes:
// tdata is the byte for the display controller, tuser is 1 for a character data
// write and 0 for an instruction write, and tlast marks the final write caused by
// one input byte. A string packet (opcode 0) collects qualifier characters and sends
// them all when the last one arrives; opcode 1 updates the line count or large-font
// flag and sends a function-set instruction; opcode 2 latches a row and takes a
// column byte, then sends the set-address instruction; opcode 3 sends the 15-character
// version text or a clear instruction. Timing: a byte that causes no write leaves the
// port ready, so the next byte can follow at once. A single instruction write passes
// S_SINGLE and the output register; the port is ready again in the cycle it appears.
// A buffered string passes each character through S_STR_RD and then S_STR_WR, since
// it goes through the registered read port of the character buffer; the version text
// costs one cycle per character. The slave port stays low on tready while writes of
// a packet are still being produced, and an output stall holds the whole sequence.
`default_nettype none
module lcd_command_packet_translator_core #(
    parameter int BUFFER_DEPTH = lcd_cpt_pkg::LCD_BUFFER_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Slave stream.
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [6:0] in_byte, [7] zero
    // Master stream.
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] lcd_byte
    output logic            o_m_axis_tuser,   // [0] is_data
    output logic            o_m_axis_tlast    // last write caused by one input byte
);
    import lcd_cpt_pkg::*;

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    // The controller sequences the writes of one packet at a time.
    lcd_cpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (w_status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the parse state, display flags, character buffer and
    // the output register that separates the two stream sides.
    lcd_cpt_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_byte     (i_s_axis_tdata[IN_BYTE_W-1:0]),
        .i_cmd         (w_cmd),
        .i_out_ready   (i_m_axis_tready),
        .o_status      (w_status),
        .o_out_valid   (o_m_axis_tvalid),
        .o_out_is_data (o_m_axis_tuser),
        .o_out_byte    (o_m_axis_tdata),
        .o_out_last    (o_m_axis_tlast)
    );

endmodule
`default_nettype wire

FILE: design/lcd_cpt_checker.sv
`default_nettype none
`include "lcd_command_packet_translator_core_assert.svh"
module lcd_cpt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_tready,
    input wire logic       i_m_tvalid,
    input wire logic       i_m_axis_tready,
    input wire logic [7:0] i_m_tdata,
    input wire logic       i_m_tuser,
    input wire logic       i_m_tlast
);
    // A stalled write holds its contents.
    `LCPT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_axis_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast), "master stream changed while stalled")
    // No new byte is taken while a multi-write sequence is unfinished.
    `LCPT_ASSERT_NOW(a_busy_in_seq, i_clk, i_rst_n, i_m_tvalid && !i_m_tlast, !i_s_tready, "input ready in the middle of a write sequence")
    // After a non-final write is taken, input stays blocked until the next write shows.
    `LCPT_ASSERT_NEXT(a_seq_continues, i_clk, i_rst_n, i_m_tvalid && i_m_axis_tready && !i_m_tlast, i_m_tvalid || !i_s_tready, "input ready with no write pending after a non-final write")
    // Instruction writes are always single writes.
    `LCPT_ASSERT_NOW(a_instr_single, i_clk, i_rst_n, i_m_tvalid && !i_m_tuser, i_m_tlast, "instruction write without tlast")
endmodule

bind lcd_command_packet_translator_core lcd_cpt_checker u_lcd_cpt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_tready      (o_s_axis_tready),
    .i_m_tvalid      (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_tdata       (o_m_axis_tdata),
    .i_m_tuser       (o_m_axis_tuser),
    .i_m_tlast       (o_m_axis_tlast)
);
`default_nettype wire

FILE: verif/tb_lcd_command_packet_translator_core.sv
`default_nettype none
module tb_lcd_command_packet_translator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lcd_cpt_pkg::*;

    // One display write as it leaves the master stream.
    typedef struct packed {
        logic                  is_data;
        logic [LCD_BYTE_W-1:0] lcd_byte;
        logic                  last;
    } t_lcd_write;

    localparam int RX_ITEMS = 410;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Slave-side drive, updated at the falling edge only.
    logic                 s_valid = 1'b0;
    logic [IN_BYTE_W-1:0] s_byte  = '0;
    logic                 m_ready = 1'b0;

    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [7:0]            o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  o_m_axis_tlast;

    // Bytes waiting to be sent and writes the display should see, in order.
    logic [IN_BYTE_W-1:0] pending_bytes[$];
    t_lcd_write           expected_writes[$];

    int  accepted_cnt = 0;
    int  popped_cnt   = 0;
    int  fail_count   = 0;
    bit  stim_done    = 1'b0;

    // Shadow of the translator state, advanced on every accepted byte.
    logic [1:0]           sh_phase;
    logic [QUAL_W-1:0]    sh_str_len;
    logic [QUAL_W-1:0]    sh_str_idx;
    logic [IN_BYTE_W-1:0] sh_chars [0:LCD_BUFFER_DEPTH-1];
    logic [1:0]           sh_lines;
    logic                 sh_big_font;
    logic [1:0]           sh_row;

    // Row start addresses of a four-line character display.
    logic [LCD_BYTE_W-1:0] row_base [0:3] = '{8'h00, 8'h40, 8'h14, 8'h54};
    string                 banner_text    = "LCD display v.2";

    lcd_command_packet_translator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  ({1'b0, s_byte}),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [IN_BYTE_W-1:0] header(input logic [1:0] op,
                                                    input logic [QUAL_W-1:0] qual);
        return {op, qual};
    endfunction

    task automatic push_write(input logic is_data, input logic [LCD_BYTE_W-1:0] b,
                              input logic last);
        t_lcd_write w;
        w.is_data  = is_data;
        w.lcd_byte = b;
        w.last     = last;
        expected_writes.push_back(w);
    endtask

    // Function-set instruction built from the current line count and font flag.
    task automatic push_function_set();
        logic [LCD_BYTE_W-1:0] cmd;
        cmd = CMD_FUNCTION;
        cmd[3] = (sh_lines != 2'd0);
        cmd[2] = sh_big_font;
        push_write(1'b0, cmd, 1'b1);
    endtask

    // Advances the shadow state by one byte and queues the writes it causes.
    task automatic predict_writes(input logic [IN_BYTE_W-1:0] b);
        logic [1:0]            op;
        logic [QUAL_W-1:0]     qual;
        logic [LCD_BYTE_W-1:0] addr;
        op   = b[6:5];
        qual = b[4:0];
        if (sh_phase == PH_STRING) begin
            sh_chars[sh_str_idx] = b;
            sh_str_idx = sh_str_idx + 1'b1;
            if (sh_str_idx >= sh_str_len) begin
                // The whole string goes out once its last character has arrived.
                for (int i = 0; i < int'(sh_str_len); i++)
                    push_write(1'b1, {1'b0, sh_chars[i]}, i == int'(sh_str_len) - 1);
                sh_phase   = PH_HEADER;
                sh_str_idx = '0;
            end
        end else if (sh_phase == PH_GOTO) begin
            // The column is added to the row base and wraps at 8 bits.
            addr = CMD_ADDRESS | (row_base[sh_row] + {1'b0, b});
            push_write(1'b0, addr, 1'b1);
            sh_phase = PH_HEADER;
        end else begin
            // Awaiting a header; an unused phase code behaves the same way.
            sh_phase = PH_HEADER;
            case (op)
                OP_STRING: begin
                    sh_str_len = qual;
                    sh_str_idx = '0;
                    if (qual != '0)
                        sh_phase = PH_STRING;
                end
                OP_CONFIG: begin
                    if (qual == QUAL_CFG_ONE_LINE || qual == QUAL_CFG_TWO_LINE ||
                        qual == QUAL_CFG_SIZE3) begin
                        sh_lines = qual[1:0];
                        if (sh_lines != 2'd0)
                            sh_big_font = 1'b0;
                        push_function_set();
                    end else if (qual == QUAL_CFG_LARGE) begin
                        // The large font only exists outside one-line mode.
                        if (sh_lines != 2'd0)
                            sh_big_font = 1'b1;
                        push_function_set();
                    end
                end
                OP_GOTO: begin
                    sh_row   = qual[1:0];
                    sh_phase = PH_GOTO;
                end
                default: begin
                    if (qual == QUAL_GEN_VERSION) begin
                        for (int i = 0; i < banner_text.len(); i++)
                            push_write(1'b1, banner_text[i], i == banner_text.len() - 1);
                    end else if (qual == QUAL_GEN_CLEAR) begin
                        push_write(1'b0, CMD_CLEAR, 1'b1);
                    end
                end
            endcase
        end
    endtask

    // Builds the byte stream: a directed opening, then mostly well-formed packets.
    task automatic build_stimulus();
        int                pick;
        int                len;
        logic [QUAL_W-1:0] qual;
        // Font and line-count corners, including large font refused in one-line mode.
        pending_bytes.push_back(header(OP_CONFIG, QUAL_CFG_LARGE));
        pending_bytes.push_back(header(OP_CONFIG, QUAL_CFG_ONE_LINE));
        pending_bytes.push_back(header(OP_CONFIG, QUAL_CFG_LARGE));
        pending_bytes.push_back(header(OP_CONFIG, QUAL_CFG_SIZE3));
        pending_bytes.push_back(header(OP_CONFIG, QUAL_CFG_LARGE));
        pending_bytes.push_back(header(OP_CONFIG, QUAL_CFG_TWO_LINE));
        pending_bytes.push_back(header(OP_CONFIG, 5'd31));
        // Empty string, then strings whose characters look like headers.
        pending_bytes.push_back(header(OP_STRING, 5'd0));
        pending_bytes.push_back(header(OP_STRING, 5'd1));
        pending_bytes.push_back(7'h7F);
        pending_bytes.push_back(header(OP_STRING, 5'd2));
        pending_bytes.push_back(7'h00);
        pending_bytes.push_back(header(OP_GENERIC, QUAL_GEN_VERSION));
        // Goto with every row, high qualifier bits set, and column extremes.
        pending_bytes.push_back(header(OP_GOTO, 5'd31));
        pending_bytes.push_back(7'h7F);
        pending_bytes.push_back(header(OP_GOTO, 5'd0));
        pending_bytes.push_back(7'h00);
        pending_bytes.push_back(header(OP_GOTO, 5'd5));
        pending_bytes.push_back(7'h2A);
        pending_bytes.push_back(header(OP_GOTO, 5'd2));
        pending_bytes.push_back(7'h40);
        pending_bytes.push_back(header(OP_GENERIC, QUAL_GEN_VERSION));
        pending_bytes.push_back(header(OP_GENERIC, QUAL_GEN_CLEAR));
        pending_bytes.push_back(header(OP_GENERIC, 5'd31));

        while (pending_bytes.size() < RX_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 32) begin
                // Strings are mostly short; now and then the longest string, 31 characters, is sent.
                len = ($urandom_range(0, 11) == 0) ? 31 : $urandom_range(1, 6);
                if ($urandom_range(0, 19) == 0)
                    len = 0;
                pending_bytes.push_back(header(OP_STRING, len[4:0]));
                for (int i = 0; i < len; i++)
                    pending_bytes.push_back(7'($urandom_range(0, 127)));
            end else if (pick < 50) begin
                qual = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(0, 3));
                pending_bytes.push_back(header(OP_CONFIG, qual));
            end else if (pick < 72) begin
                pending_bytes.push_back(header(OP_GOTO, 5'($urandom_range(0, 31))));
                pending_bytes.push_back(7'($urandom_range(0, 127)));
            end else if (pick < 88) begin
                if ($urandom_range(0, 5) == 0)
                    qual = 5'($urandom_range(0, 31));
                else if ($urandom_range(0, 2) == 0)
                    qual = QUAL_GEN_VERSION;
                else
                    qual = QUAL_GEN_CLEAR;
                pending_bytes.push_back(header(OP_GENERIC, qual));
            end else begin
                // Noise: a stray byte that may start or cut into any packet.
                pending_bytes.push_back(7'($urandom_range(0, 127)));
            end
        end
    endtask

    // Sender: bursts of random length separated by random gaps. A byte stays
    // on the bus until its transfer, and it is dropped from the queue only then.
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        logic                 nxt_valid;
        logic [IN_BYTE_W-1:0] nxt_byte;
        nxt_valid = s_valid;
        nxt_byte  = s_byte;
        if (i_rst_n) begin
            if (!(s_valid && accepted_cnt == popped_cnt)) begin
                if (s_valid) begin
                    void'(pending_bytes.pop_front());
                    popped_cnt++;
                end
                nxt_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stim_done && pending_bytes.size() > 0) begin
                    nxt_valid = 1'b1;
                    nxt_byte  = pending_bytes[0];
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
        s_valid <= nxt_valid;
        s_byte  <= nxt_byte;
    end

    // Receiver: stretches of always-ready, coin-flip, mostly-stalled and
    // periodic back-pressure, each of random length.
    int rx_mode    = 0;
    int rx_stretch = 0;
    int rx_tick    = 0;

    always @(negedge i_clk) begin
        logic nxt_ready;
        if (rx_stretch == 0) begin
            rx_mode    = $urandom_range(0, 3);
            rx_stretch = $urandom_range(10, 120);
        end
        rx_stretch--;
        rx_tick++;
        case (rx_mode)
            0:       nxt_ready = 1'b1;
            1:       nxt_ready = 1'($urandom_range(0, 1));
            2:       nxt_ready = ($urandom_range(0, 7) == 0);
            default: nxt_ready = (rx_tick % 3 != 0);
        endcase
        m_ready <= nxt_ready;
    end

    // Monitor: every write transfer is checked against the oldest expectation,
    // and every byte transfer advances the shadow state. A write can never
    // belong to a byte taken at the same edge, so the order here is safe.
    always @(posedge i_clk) begin
        t_lcd_write want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && m_ready) begin
                if (expected_writes.size() == 0) begin
                    $error("write with nothing expected: tdata %h tuser %b tlast %b",
                           o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                    fail_count++;
                end else begin
                    want = expected_writes.pop_front();
                    if (o_m_axis_tuser !== want.is_data) begin
                        $error("is_data: expected %b, actual %b", want.is_data,
                               o_m_axis_tuser);
                        fail_count++;
                    end
                    if (o_m_axis_tdata !== want.lcd_byte) begin
                        $error("lcd_byte: expected %h, actual %h", want.lcd_byte,
                               o_m_axis_tdata);
                        fail_count++;
                    end
                    if (o_m_axis_tlast !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, o_m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_valid && o_s_axis_tready) begin
                predict_writes(s_byte);
                accepted_cnt++;
            end
        end
    end

    initial begin
        sh_phase    = PH_HEADER;
        sh_str_len  = '0;
        sh_str_idx  = '0;
        sh_lines    = DISPLAY_MODE_RESET;
        sh_big_font = 1'b0;
        sh_row      = 2'd0;
        foreach (sh_chars[i])
            sh_chars[i] = '0;
        build_stimulus();
        stim_done = 1'b1;

        // Reset is held low at the start and released at a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Wait for every byte to be taken and every write to come out.
        while (pending_bytes.size() > 0 || s_valid)
            @(posedge i_clk);
        while (expected_writes.size() > 0)
            @(posedge i_clk);
        // A trailing byte may still be in flight; give the block time to settle.
        repeat (50) @(posedge i_clk);

        if (expected_writes.size() != 0) begin
            $error("%0d expected writes never arrived", expected_writes.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

FILE: lcd_command_packet_translator_core.f
+incdir+design
design/lcd_cpt_pkg.sv
design/lcd_cpt_dp.sv
design/lcd_cpt_ctrl.sv
design/lcd_command_packet_translator_core.sv
design/lcd_cpt_checker.sv
verif/tb_lcd_command_packet_translator_core.sv
